@@ rtl/bw_pkg.sv @@
// ---------------------------------------------------------------------------
// bw_pkg: shared types and widths for the barycentric weight pipeline
// Holds the payload structs, the internal word widths and the default
// fraction width of the weights.
// ---------------------------------------------------------------------------
`default_nettype none

package bw_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PP_W      = 2 * DIFF_W;
  localparam int DOT_W     = PP_W + 2;
  localparam int HALF_W    = DOT_W / 2;
  localparam int PROD_W    = 2 * DOT_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int WEIGHT_W  = 32;

  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PP_W-1:0]   pp_t;
  typedef logic signed [DOT_W-1:0]  dot_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] p_z;
  } bw_in_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_u;
    logic signed [WEIGHT_W-1:0] weight_v;
    logic signed [WEIGHT_W-1:0] weight_w;
    logic                       degenerate;
    logic                       saturated;
  } bw_out_t;

  typedef struct packed {
    dot_t d00;
    dot_t d01;
    dot_t d11;
    dot_t d20;
    dot_t d21;
  } bw_dots_t;

  // side flags that ride along with the divider stages
  typedef struct packed {
    logic neg_v;
    logic neg_w;
    logic degen;
  } bw_tag_t;

endpackage

`default_nettype wire

@@ rtl/bw_front.sv @@
// ---------------------------------------------------------------------------
// bw_front: edge vectors and dot products
// Three register stages: coordinate differences, element products, sums.
// ---------------------------------------------------------------------------
`default_nettype none

module bw_front import bw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  bw_in_t   in_data,
  output logic     dots_valid,
  output bw_dots_t dots
);

  logic signed [COORD_W-1:0] ca [3];
  logic signed [COORD_W-1:0] cb [3];
  logic signed [COORD_W-1:0] cc [3];
  logic signed [COORD_W-1:0] cp [3];

  diff_t e0 [3];
  diff_t e1 [3];
  diff_t e2 [3];
  pp_t   p00 [3];
  pp_t   p01 [3];
  pp_t   p11 [3];
  pp_t   p20 [3];
  pp_t   p21 [3];
  logic [1:0] vld;

  always_comb begin
    ca[0] = in_data.a_x; ca[1] = in_data.a_y; ca[2] = in_data.a_z;
    cb[0] = in_data.b_x; cb[1] = in_data.b_y; cb[2] = in_data.b_z;
    cc[0] = in_data.c_x; cc[1] = in_data.c_y; cc[2] = in_data.c_z;
    cp[0] = in_data.p_x; cp[1] = in_data.p_y; cp[2] = in_data.p_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      dots_valid <= 1'b0;
    end else if (en) begin
      vld        <= {vld[0], in_valid};
      dots_valid <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e0[k]  <= DIFF_W'(cb[k]) - DIFF_W'(ca[k]);
        e1[k]  <= DIFF_W'(cc[k]) - DIFF_W'(ca[k]);
        e2[k]  <= DIFF_W'(cp[k]) - DIFF_W'(ca[k]);
        p00[k] <= PP_W'(e0[k]) * PP_W'(e0[k]);
        p01[k] <= PP_W'(e0[k]) * PP_W'(e1[k]);
        p11[k] <= PP_W'(e1[k]) * PP_W'(e1[k]);
        p20[k] <= PP_W'(e2[k]) * PP_W'(e0[k]);
        p21[k] <= PP_W'(e2[k]) * PP_W'(e1[k]);
      end
      dots.d00 <= DOT_W'(p00[0]) + DOT_W'(p00[1]) + DOT_W'(p00[2]);
      dots.d01 <= DOT_W'(p01[0]) + DOT_W'(p01[1]) + DOT_W'(p01[2]);
      dots.d11 <= DOT_W'(p11[0]) + DOT_W'(p11[1]) + DOT_W'(p11[2]);
      dots.d20 <= DOT_W'(p20[0]) + DOT_W'(p20[1]) + DOT_W'(p20[2]);
      dots.d21 <= DOT_W'(p21[0]) + DOT_W'(p21[1]) + DOT_W'(p21[2]);
    end
  end

endmodule

`default_nettype wire

@@ rtl/bw_mul.sv @@
// ---------------------------------------------------------------------------
// bw_mul: two-stage signed dot x dot multiplier
// Splits each operand into a signed high half and an unsigned low half,
// registers the four partial products and sums them in the next stage.
// ---------------------------------------------------------------------------
`default_nettype none

module bw_mul import bw_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  dot_t  a,
  input  dot_t  b,
  output prod_t p
);

  localparam int HI_W = DOT_W - HALF_W;

  logic signed [2*HI_W-1:0]      pp_hh;
  logic signed [HI_W+HALF_W:0]   pp_hl;
  logic signed [HI_W+HALF_W:0]   pp_lh;
  logic        [2*HALF_W-1:0]    pp_ll;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hh <= (2*HI_W)'($signed(a[DOT_W-1:HALF_W])) * (2*HI_W)'($signed(b[DOT_W-1:HALF_W]));
      pp_hl <= (HI_W+HALF_W+1)'($signed(a[DOT_W-1:HALF_W]))
             * (HI_W+HALF_W+1)'($signed({1'b0, b[HALF_W-1:0]}));
      pp_lh <= (HI_W+HALF_W+1)'($signed(b[DOT_W-1:HALF_W]))
             * (HI_W+HALF_W+1)'($signed({1'b0, a[HALF_W-1:0]}));
      pp_ll <= (2*HALF_W)'(a[HALF_W-1:0]) * (2*HALF_W)'(b[HALF_W-1:0]);
      p     <= (PROD_W'(pp_hh) <<< (2*HALF_W))
             + (PROD_W'(pp_hl) <<< HALF_W)
             + (PROD_W'(pp_lh) <<< HALF_W)
             + $signed(PROD_W'(pp_ll));
    end
  end

endmodule

`default_nettype wire

@@ rtl/bw_div.sv @@
// ---------------------------------------------------------------------------
// bw_div: pipelined restoring divider, two dividends over one divisor
// One quotient bit per stage; the dividend register shifts the quotient
// in from the bottom as it is consumed from the top.
// ---------------------------------------------------------------------------
`default_nettype none

module bw_div import bw_pkg::*; #(
  parameter int DVD_W = MAG_W + WEIGHT_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [MAG_W-1:0] divisor,
  input  logic [DVD_W-1:0] dvd_v,
  input  logic [DVD_W-1:0] dvd_w,
  input  bw_tag_t          tag_in,
  output logic             out_valid,
  output logic [DVD_W-1:0] quo_v,
  output logic [DVD_W-1:0] quo_w,
  output bw_tag_t          tag_out
);

  logic [MAG_W-1:0] rem_v [DVD_W];
  logic [MAG_W-1:0] rem_w [DVD_W];
  logic [DVD_W-1:0] dq_v  [DVD_W];
  logic [DVD_W-1:0] dq_w  [DVD_W];
  logic [MAG_W-1:0] dsr   [DVD_W];
  bw_tag_t          tg    [DVD_W];
  logic [DVD_W-1:0] vld;

  for (genvar i = 0; i < DVD_W; i++) begin : g_stage
    logic [MAG_W-1:0] rv_in;
    logic [MAG_W-1:0] rw_in;
    logic [DVD_W-1:0] qv_in;
    logic [DVD_W-1:0] qw_in;
    logic [MAG_W-1:0] d_in;
    bw_tag_t          t_in;
    logic             v_in;
    logic [MAG_W:0]   tv;
    logic [MAG_W:0]   tw;
    logic [MAG_W:0]   sub_v;
    logic [MAG_W:0]   sub_w;
    logic             ge_v;
    logic             ge_w;

    if (i == 0) begin : g_first
      assign rv_in = '0;
      assign rw_in = '0;
      assign qv_in = dvd_v;
      assign qw_in = dvd_w;
      assign d_in  = divisor;
      assign t_in  = tag_in;
      assign v_in  = in_valid;
    end else begin : g_next
      assign rv_in = rem_v[i-1];
      assign rw_in = rem_w[i-1];
      assign qv_in = dq_v[i-1];
      assign qw_in = dq_w[i-1];
      assign d_in  = dsr[i-1];
      assign t_in  = tg[i-1];
      assign v_in  = vld[i-1];
    end

    assign tv    = {rv_in, qv_in[DVD_W-1]};
    assign tw    = {rw_in, qw_in[DVD_W-1]};
    assign sub_v = tv - {1'b0, d_in};
    assign sub_w = tw - {1'b0, d_in};
    assign ge_v  = tv >= {1'b0, d_in};
    assign ge_w  = tw >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_v[i] <= ge_v ? sub_v[MAG_W-1:0] : tv[MAG_W-1:0];
        rem_w[i] <= ge_w ? sub_w[MAG_W-1:0] : tw[MAG_W-1:0];
        dq_v[i]  <= {qv_in[DVD_W-2:0], ge_v};
        dq_w[i]  <= {qw_in[DVD_W-2:0], ge_w};
        dsr[i]   <= d_in;
        tg[i]    <= t_in;
      end
    end
  end

  assign out_valid = vld[DVD_W-1];
  assign quo_v     = dq_v[DVD_W-1];
  assign quo_w     = dq_w[DVD_W-1];
  assign tag_out   = tg[DVD_W-1];

endmodule

`default_nettype wire

@@ rtl/barycentric_weights_top.sv @@
// ---------------------------------------------------------------------------
// barycentric_weights_top: barycentric weights of a point in a 3-D triangle
//
//   channel  handshake            payload
//   in       in_valid / in_ready  in_data  (bw_in_t, corners a b c, point p)
//   out      out_valid / out_ready out_data (bw_out_t, u v w, flags)
//
// Accepts one transaction per cycle while the pipeline is not stalled; the
// divider resolves one quotient bit per stage. Reset clears all valid bits;
// payload registers are not reset. When the output register holds a result
// that is not taken, the whole pipeline holds, and in_ready drops with it.
// ---------------------------------------------------------------------------
`default_nettype none

module barycentric_weights_top import bw_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  bw_in_t  in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output bw_out_t out_data
);

  localparam int DVD_W = MAG_W + WEIGHT_FRAC_BITS;
  localparam int SUM_W = DVD_W + 3;
  localparam logic signed [SUM_W-1:0] ONE_W =
    {{(SUM_W-1){1'b0}}, 1'b1} << WEIGHT_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] W_MAX = SUM_W'({1'b0, {(WEIGHT_W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] W_MIN = -W_MAX - 1;

  logic en;

  logic     dots_valid;
  bw_dots_t dots;

  prod_t p_00_11, p_01_01, p_11_20, p_01_21, p_00_21, p_01_20;
  logic [1:0] mul_vld;

  logic signed [NUM_W-1:0] den_s, nv_s, nw_s;
  logic                    num_vld;

  logic signed [NUM_W-1:0] nv_neg, nw_neg;
  logic [MAG_W-1:0]        mag_v, mag_w;

  logic [MAG_W-1:0] div_dsr;
  logic [DVD_W-1:0] div_dvd_v, div_dvd_w;
  bw_tag_t          div_tag;
  logic             sign_vld;

  logic [DVD_W-1:0] quo_v, quo_w;
  bw_tag_t          quo_tag;
  logic             div_vld;

  logic signed [DVD_W:0] sv, sw;
  logic                  fix_degen;
  logic                  fix_vld;

  logic signed [SUM_W-1:0] wu, wv, ww;
  logic [WEIGHT_W:0]       su, sv_sat, sw_sat;

  function automatic logic [WEIGHT_W:0] sat(input logic signed [SUM_W-1:0] x);
    logic [WEIGHT_W:0] r;
    if (x > W_MAX) begin
      r = {1'b1, W_MAX[WEIGHT_W-1:0]};
    end else if (x < W_MIN) begin
      r = {1'b1, W_MIN[WEIGHT_W-1:0]};
    end else begin
      r = {1'b0, x[WEIGHT_W-1:0]};
    end
    return r;
  endfunction

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  bw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .dots_valid (dots_valid),
    .dots       (dots)
  );

  bw_mul u_mul0 (.clk(clk), .en(en), .a(dots.d00), .b(dots.d11), .p(p_00_11));
  bw_mul u_mul1 (.clk(clk), .en(en), .a(dots.d01), .b(dots.d01), .p(p_01_01));
  bw_mul u_mul2 (.clk(clk), .en(en), .a(dots.d11), .b(dots.d20), .p(p_11_20));
  bw_mul u_mul3 (.clk(clk), .en(en), .a(dots.d01), .b(dots.d21), .p(p_01_21));
  bw_mul u_mul4 (.clk(clk), .en(en), .a(dots.d00), .b(dots.d21), .p(p_00_21));
  bw_mul u_mul5 (.clk(clk), .en(en), .a(dots.d01), .b(dots.d20), .p(p_01_20));

  // numerator magnitudes; the gram determinant is never negative
  assign nv_neg = -nv_s;
  assign nw_neg = -nw_s;
  assign mag_v  = nv_s[NUM_W-1] ? nv_neg[MAG_W-1:0] : nv_s[MAG_W-1:0];
  assign mag_w  = nw_s[NUM_W-1] ? nw_neg[MAG_W-1:0] : nw_s[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld  <= '0;
      num_vld  <= 1'b0;
      sign_vld <= 1'b0;
      fix_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_vld   <= {mul_vld[0], dots_valid};
      num_vld   <= mul_vld[1];
      sign_vld  <= num_vld;
      fix_vld   <= div_vld;
      out_valid <= fix_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_s <= NUM_W'(p_00_11) - NUM_W'(p_01_01);
      nv_s  <= NUM_W'(p_11_20) - NUM_W'(p_01_21);
      nw_s  <= NUM_W'(p_00_21) - NUM_W'(p_01_20);

      div_dsr       <= den_s[MAG_W-1:0];
      div_dvd_v     <= DVD_W'(mag_v) << WEIGHT_FRAC_BITS;
      div_dvd_w     <= DVD_W'(mag_w) << WEIGHT_FRAC_BITS;
      div_tag.neg_v <= nv_s[NUM_W-1];
      div_tag.neg_w <= nw_s[NUM_W-1];
      div_tag.degen <= (den_s == '0);
    end
  end

  bw_div #(.DVD_W(DVD_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sign_vld),
    .divisor   (div_dsr),
    .dvd_v     (div_dvd_v),
    .dvd_w     (div_dvd_w),
    .tag_in    (div_tag),
    .out_valid (div_vld),
    .quo_v     (quo_v),
    .quo_w     (quo_w),
    .tag_out   (quo_tag)
  );

  assign wv     = SUM_W'(sv);
  assign ww     = SUM_W'(sw);
  assign wu     = ONE_W - wv - ww;
  assign su     = sat(wu);
  assign sv_sat = sat(wv);
  assign sw_sat = sat(ww);

  always_ff @(posedge clk) begin
    if (en) begin
      sv <= quo_tag.neg_v ? -$signed({1'b0, quo_v}) : $signed({1'b0, quo_v});
      sw <= quo_tag.neg_w ? -$signed({1'b0, quo_w}) : $signed({1'b0, quo_w});
      fix_degen <= quo_tag.degen;

      if (fix_degen) begin
        out_data.weight_u   <= '0;
        out_data.weight_v   <= '0;
        out_data.weight_w   <= '0;
        out_data.degenerate <= 1'b1;
        out_data.saturated  <= 1'b0;
      end else begin
        out_data.weight_u   <= su[WEIGHT_W-1:0];
        out_data.weight_v   <= sv_sat[WEIGHT_W-1:0];
        out_data.weight_w   <= sw_sat[WEIGHT_W-1:0];
        out_data.degenerate <= 1'b0;
        out_data.saturated  <= su[WEIGHT_W] | sv_sat[WEIGHT_W] | sw_sat[WEIGHT_W];
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/barycentric_weights_top_tb.sv @@
// ---------------------------------------------------------------------------
// barycentric_weights_top_tb: checks the barycentric weight pipeline
// Sends triangles and query points over the input channel with random gaps,
// predicts each weight triple in full precision and compares every result
// transaction in order, with random and long stalls on the output side.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module barycentric_weights_top_tb import bw_pkg::*; ();

  typedef logic signed [127:0] wide_t;

  localparam int FRAC      = WEIGHT_FRAC_BITS_DEF;
  localparam int LATENCY   = 9 + 72 + FRAC;
  localparam int IDLE_MAX  = 5000;
  localparam int LONG_HOLD = 400;

  logic    clk;
  logic    rst;
  logic    in_valid;
  logic    in_ready;
  bw_in_t  in_data;
  logic    out_valid;
  logic    out_ready;
  bw_out_t out_data;

  bw_out_t weights_q[$];
  int      fails;
  int      idle_cycles;
  logic    hold_req;

  barycentric_weights_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic signed [31:0] clip32(input wide_t x, inout logic clipped);
    if (x > wide_t'(64'sd2147483647)) begin
      clipped = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -wide_t'(64'sd2147483648)) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic bw_out_t weigh_point(input bw_in_t t);
    longint e0[3], e1[3], e2[3];
    longint d00, d01, d11, d20, d21;
    wide_t  den, nv, nw, qv, qw, qu;
    logic   clipped;
    bw_out_t r;
    e0[0] = longint'(t.b_x) - t.a_x; e0[1] = longint'(t.b_y) - t.a_y;
    e0[2] = longint'(t.b_z) - t.a_z;
    e1[0] = longint'(t.c_x) - t.a_x; e1[1] = longint'(t.c_y) - t.a_y;
    e1[2] = longint'(t.c_z) - t.a_z;
    e2[0] = longint'(t.p_x) - t.a_x; e2[1] = longint'(t.p_y) - t.a_y;
    e2[2] = longint'(t.p_z) - t.a_z;
    d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
    d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
    d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
    d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
    den = wide_t'(d00) * wide_t'(d11) - wide_t'(d01) * wide_t'(d01);
    r = '0;
    if (den == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    nv = wide_t'(d11) * wide_t'(d20) - wide_t'(d01) * wide_t'(d21);
    nw = wide_t'(d00) * wide_t'(d21) - wide_t'(d01) * wide_t'(d20);
    // signed division truncates toward zero
    qv = (nv <<< FRAC) / den;
    qw = (nw <<< FRAC) / den;
    qu = (wide_t'(1) <<< FRAC) - qv - qw;
    clipped = 1'b0;
    r.weight_u = clip32(qu, clipped);
    r.weight_v = clip32(qv, clipped);
    r.weight_w = clip32(qw, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  // sender: called at a rising edge, returns at a rising edge
  task automatic send_query(input bw_in_t t);
    int gap;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    weights_q.push_back(weigh_point(t));
    case ($urandom_range(0, 19))
      0: gap = $urandom_range(10, 40);
      1, 2, 3, 4: gap = $urandom_range(1, 3);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (weights_q.size() != 0) @(posedge clk);
  endtask

  function automatic bw_in_t mk(input int ax, ay, az, bx, by, bz,
                                input int cx, cy, cz, px, py, pz);
    bw_in_t t;
    t.a_x = 16'(ax); t.a_y = 16'(ay); t.a_z = 16'(az);
    t.b_x = 16'(bx); t.b_y = 16'(by); t.b_z = 16'(bz);
    t.c_x = 16'(cx); t.c_y = 16'(cy); t.c_z = 16'(cz);
    t.p_x = 16'(px); t.p_y = 16'(py); t.p_z = 16'(pz);
    return t;
  endfunction

  function automatic int rnd_coord(input int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic bw_in_t random_query();
    bw_in_t t;
    int span, k;
    case ($urandom_range(0, 9))
      0, 1: t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      2: begin
        // collinear corners: degenerate triangle
        span = 2000;
        k = rnd_coord(4);
        t = mk(rnd_coord(span), rnd_coord(span), rnd_coord(span), 0, 0, 0,
               0, 0, 0, rnd_coord(32767), rnd_coord(32767), rnd_coord(32767));
        t.b_x = 16'(t.a_x + rnd_coord(1000)); t.b_y = 16'(t.a_y + rnd_coord(1000));
        t.b_z = 16'(t.a_z + rnd_coord(1000));
        t.c_x = 16'(t.a_x + k * (t.b_x - t.a_x));
        t.c_y = 16'(t.a_y + k * (t.b_y - t.a_y));
        t.c_z = 16'(t.a_z + k * (t.b_z - t.a_z));
      end
      3: begin
        // tiny triangle, far point: weights clip
        t = mk(rnd_coord(100), rnd_coord(100), 0, 0, 0, 0, 0, 0, 0,
               rnd_coord(32767), rnd_coord(32767), rnd_coord(32767));
        t.b_x = 16'(t.a_x + rnd_coord(1) + 2); t.b_y = t.a_y; t.b_z = 16'(rnd_coord(1));
        t.c_x = t.a_x; t.c_y = 16'(t.a_y + rnd_coord(1) + 2); t.c_z = 16'(rnd_coord(1));
      end
      default: begin
        span = ($urandom_range(0, 1) != 0) ? 256 : 8000;
        t = mk(rnd_coord(span), rnd_coord(span), rnd_coord(span),
               rnd_coord(span), rnd_coord(span), rnd_coord(span),
               rnd_coord(span), rnd_coord(span), rnd_coord(span),
               rnd_coord(span), rnd_coord(span), rnd_coord(span));
      end
    endcase
    return t;
  endfunction

  task automatic test_directed();
    send_query(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk(32767, 32767, 32767, 32767, 32767, 32767,
                  32767, 32767, 32767, 32767, 32767, 32767));
    send_query(mk(-32768, -32768, -32768, 32767, -32768, -32768,
                  -32768, 32767, -32768, 32767, 32767, 32767));
    send_query(mk(32767, 32767, 32767, -32768, 32767, 32767,
                  32767, -32768, 32767, -32768, -32768, -32768));
    send_query(mk(-32768, 0, 0, 32767, 0, 0, -32768, 32767, 32767, 0, 0, 0));
    // unit triangle, point at each corner, the centroid and a point off the plane
    send_query(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0));
    send_query(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0));
    send_query(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0));
    send_query(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 85, 85, 0));
    send_query(mk(0, 0, 0, 256, 0, 0, 0, 256, 0, 100, 100, 300));
    // coincident corners and collinear corners
    send_query(mk(5, -7, 9, 5, -7, 9, 100, 3, -4, 1, 2, 3));
    send_query(mk(0, 0, 0, 10, 20, 30, -20, -40, -60, 7, 7, 7));
    // far points: positive and negative clipping
    send_query(mk(-32768, 0, 0, -32767, 0, 0, -32768, 1, 0, 32767, 0, 0));
    send_query(mk(32767, 0, 0, 32766, 0, 0, 32767, 1, 0, -32768, 0, 0));
    send_query(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, -32768, -32768, 0));
    send_query(mk(0, 0, 0, 1, 0, 0, 0, 1, 0, 32767, 32767, 32767));
    wait_drained();
  endtask

  task automatic test_random(input int count);
    repeat (count) send_query(random_query());
    wait_drained();
  endtask

  // output held off long enough that the pipeline fills and stalls input
  task automatic test_backpressure();
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (250) send_query(random_query());
    wait_drained();
  endtask

  // receiver: random stalls, stretches of none, and a long hold on request
  initial begin
    int hold, mode;
    out_ready = 1'b0;
    hold = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req) hold = LONG_HOLD;
      if ($urandom_range(0, 199) == 0) mode = $urandom_range(0, 2);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (mode == 0) begin
        out_ready <= 1'b1;
      end else if (mode == 1) begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 29) == 0) begin
        hold = $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 1) != 0);
      end
    end
  end

  always @(posedge clk) begin
    bw_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (weights_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fails++;
      end else begin
        want = weights_q.pop_front();
        if (out_data.weight_u !== want.weight_u) begin
          $error("weight_u: expected %0d, got %0d", want.weight_u, out_data.weight_u);
          fails++;
        end
        if (out_data.weight_v !== want.weight_v) begin
          $error("weight_v: expected %0d, got %0d", want.weight_v, out_data.weight_v);
          fails++;
        end
        if (out_data.weight_w !== want.weight_w) begin
          $error("weight_w: expected %0d, got %0d", want.weight_w, out_data.weight_w);
          fails++;
        end
        if (out_data.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate,
                 out_data.degenerate);
          fails++;
        end
        if (out_data.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, out_data.saturated);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("barycentric_weights_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fails       = 0;
    idle_cycles = 0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    hold_req    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(550);
    repeat (LATENCY + 20) @(posedge clk);
    if (fails == 0 && weights_q.size() == 0) begin
      $display("barycentric_weights_top: match");
    end else begin
      $display("barycentric_weights_top: mismatch");
    end
    $finish;
  end

endmodule
